>>> hdl/smm_pkg.sv
`default_nettype none
package smm_pkg;

  localparam int COUNT_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // number of counters carried per frame snapshot
  localparam int SNAP_COUNTERS = 5;

endpackage
`default_nettype wire

>>> hdl/smm_front.sv
`default_nettype none
module smm_front #(
  parameter int COUNT_BITS = smm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            pred_pixel,
  input  wire logic [7:0]            truth_pixel,
  input  wire logic                  last_pixel,
  output logic                       snap_valid,
  input  wire logic                  snap_ready,
  output logic [COUNT_BITS-1:0]      snap_tp,
  output logic [COUNT_BITS-1:0]      snap_fp,
  output logic [COUNT_BITS-1:0]      snap_fn,
  output logic [COUNT_BITS-1:0]      snap_tn,
  output logic [COUNT_BITS-1:0]      snap_ex,
  output logic                       snap_sat
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] tp_count, fp_count, fn_count, tn_count, ex_count;
  logic                  sat_flag;
  logic                  accept;
  logic                  pred_fg, truth_fg;
  logic                  tp_hit, fp_hit, fn_hit, tn_hit, ex_hit;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c,
                                                 input logic en);
    if (en && (c != COUNT_MAX)) begin
      return c + COUNT_BITS'(1);
    end
    return c;
  endfunction

  assign in_ready = snap_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pred_fg  = (pred_pixel != 8'd0);
    truth_fg = (truth_pixel != 8'd0);
    tp_hit   = pred_fg && truth_fg;
    fp_hit   = pred_fg && !truth_fg;
    fn_hit   = !pred_fg && truth_fg;
    tn_hit   = !pred_fg && !truth_fg;
    ex_hit   = truth_fg && (pred_pixel == truth_pixel);
    snap_tp  = bump(tp_count, tp_hit);
    snap_fp  = bump(fp_count, fp_hit);
    snap_fn  = bump(fn_count, fn_hit);
    snap_tn  = bump(tn_count, tn_hit);
    snap_ex  = bump(ex_count, ex_hit);
    snap_sat = sat_flag
             || (tp_hit && (tp_count == COUNT_MAX))
             || (fp_hit && (fp_count == COUNT_MAX))
             || (fn_hit && (fn_count == COUNT_MAX))
             || (tn_hit && (tn_count == COUNT_MAX))
             || (ex_hit && (ex_count == COUNT_MAX));
  end

  assign snap_valid = accept && last_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      tp_count <= '0;
      fp_count <= '0;
      fn_count <= '0;
      tn_count <= '0;
      ex_count <= '0;
      sat_flag <= 1'b0;
    end else if (accept) begin
      if (last_pixel) begin
        tp_count <= '0;
        fp_count <= '0;
        fn_count <= '0;
        tn_count <= '0;
        ex_count <= '0;
        sat_flag <= 1'b0;
      end else begin
        tp_count <= snap_tp;
        fp_count <= snap_fp;
        fn_count <= snap_fn;
        tn_count <= snap_tn;
        ex_count <= snap_ex;
        sat_flag <= snap_sat;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/smm_queue.sv
`default_nettype none
module smm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = smm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign push_ready = (fill != CNT_FULL);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/smm_back.sv
`default_nettype none
module smm_back #(
  parameter int COUNT_BITS    = smm_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = smm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    snap_valid,
  output logic                         snap_ready,
  input  wire logic [COUNT_BITS-1:0]   snap_tp,
  input  wire logic [COUNT_BITS-1:0]   snap_fp,
  input  wire logic [COUNT_BITS-1:0]   snap_fn,
  input  wire logic [COUNT_BITS-1:0]   snap_tn,
  input  wire logic [COUNT_BITS-1:0]   snap_ex,
  input  wire logic                    snap_sat,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [FRACTION_BITS:0]       dice_ratio,
  output logic [FRACTION_BITS:0]       jaccard_ratio,
  output logic [FRACTION_BITS:0]       specificity_ratio,
  output logic [FRACTION_BITS:0]       recall_ratio,
  output logic                         count_saturated
);

  localparam int DEN_W  = COUNT_BITS + 2;
  localparam int REM_W  = DEN_W + 1;
  localparam int Q_W    = FRACTION_BITS + 1;
  localparam int STEP_W = $clog2(FRACTION_BITS + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRACTION_BITS);
  localparam logic [Q_W-1:0]    ONE_Q     = Q_W'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_DICE,
    M_JACCARD,
    M_SPEC,
    M_RECALL
  } metric_t;

  state_t              state;
  metric_t             metric;
  logic [COUNT_BITS-1:0] tp, fp, fn, tn, ex;
  logic [DEN_W-1:0]    num, den, den_r;
  logic [Q_W-1:0]      empty_val;
  logic [REM_W-1:0]    rem, trial, diff;
  logic                ge;
  logic [Q_W-1:0]      quo, quo_next, result;
  logic [STEP_W-1:0]   step;
  logic                result_load;
  logic [Q_W-1:0]      result_val;

  function automatic logic [Q_W-1:0] clamp(input logic [Q_W-1:0] q);
    return (q > ONE_Q) ? ONE_Q : q;
  endfunction

  assign snap_ready = (state == S_IDLE);
  assign out_valid  = (state == S_DONE);

  always_comb begin
    unique case (metric)
      M_DICE: begin
        num       = DEN_W'({tp, 1'b0});
        den       = DEN_W'({tp, 1'b0}) + DEN_W'(fp) + DEN_W'(fn);
        empty_val = '0;
      end
      M_JACCARD: begin
        num       = DEN_W'(tp);
        den       = DEN_W'(tp) + DEN_W'(fp) + DEN_W'(fn);
        empty_val = '0;
      end
      M_SPEC: begin
        num       = DEN_W'(tn);
        den       = DEN_W'(tn) + DEN_W'(fp);
        empty_val = ONE_Q;
      end
      M_RECALL: begin
        num       = DEN_W'(ex);
        den       = DEN_W'(tp) + DEN_W'(fn);
        empty_val = '0;
      end
      default: begin
        num       = '0;
        den       = '0;
        empty_val = '0;
      end
    endcase
  end

  // restoring division, first step takes the integer bit without a shift
  always_comb begin
    trial    = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    ge       = (trial >= {1'b0, den_r});
    diff     = trial - {1'b0, den_r};
    quo_next = {quo[Q_W-2:0], ge};
    result   = clamp(quo_next);
  end

  always_comb begin
    result_load = 1'b0;
    result_val  = '0;
    if (state == S_SETUP && den == '0) begin
      result_load = 1'b1;
      result_val  = empty_val;
    end else if (state == S_DIV && step == STEP_LAST) begin
      result_load = 1'b1;
      result_val  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      metric <= M_DICE;
      step   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (snap_valid) begin
            tp              <= snap_tp;
            fp              <= snap_fp;
            fn              <= snap_fn;
            tn              <= snap_tn;
            ex              <= snap_ex;
            count_saturated <= snap_sat;
            metric          <= M_DICE;
            state           <= S_SETUP;
          end
        end
        S_SETUP: begin
          rem   <= REM_W'(num);
          den_r <= den;
          quo   <= '0;
          step  <= '0;
          if (den != '0) begin
            state <= S_DIV;
          end else if (metric == M_RECALL) begin
            state <= S_DONE;
          end else begin
            metric <= metric_t'(metric + 2'd1);
          end
        end
        S_DIV: begin
          rem  <= ge ? diff : trial;
          quo  <= quo_next;
          step <= step + STEP_W'(1);
          if (step == STEP_LAST) begin
            if (metric == M_RECALL) begin
              state <= S_DONE;
            end else begin
              metric <= metric_t'(metric + 2'd1);
              state  <= S_SETUP;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (result_load) begin
        unique case (metric)
          M_DICE:    dice_ratio        <= result_val;
          M_JACCARD: jaccard_ratio     <= result_val;
          M_SPEC:    specificity_ratio <= result_val;
          M_RECALL:  recall_ratio      <= result_val;
          default:   recall_ratio      <= result_val;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/segmentation_mask_metrics.sv
// channel  | handshake             | word
// ---------+-----------------------+--------------------------------------------------
// pixel in | in_valid / in_ready   | pred_pixel, truth_pixel, last_pixel
// metrics  | out_valid / out_ready | dice, jaccard, specificity, recall ratios, saturated
//
// one pixel word is taken every cycle while the frame queue has room;
// the counters update in the same cycle; each frame's result comes from the
// one shared bit-serial divider, after its counts leave the frame queue
// the input stalls only while the frame queue is full, the divider only while a result waits
// rst is synchronous; counters, queue and divider come up empty
`default_nettype none
module segmentation_mask_metrics #(
  parameter int COUNT_BITS    = smm_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = smm_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = smm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           pred_pixel,
  input  wire logic [7:0]           truth_pixel,
  input  wire logic                 last_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FRACTION_BITS:0]    dice_ratio,
  output logic [FRACTION_BITS:0]    jaccard_ratio,
  output logic [FRACTION_BITS:0]    specificity_ratio,
  output logic [FRACTION_BITS:0]    recall_ratio,
  output logic                      count_saturated
);

  localparam int SNAP_W = smm_pkg::SNAP_COUNTERS * COUNT_BITS + 1;
  localparam logic [FRACTION_BITS:0] ONE_Q = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  logic                  f_valid, f_ready, b_valid, b_ready;
  logic [COUNT_BITS-1:0] f_tp, f_fp, f_fn, f_tn, f_ex;
  logic                  f_sat;
  logic [SNAP_W-1:0]     f_data, b_data;

  smm_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pred_pixel  (pred_pixel),
    .truth_pixel (truth_pixel),
    .last_pixel  (last_pixel),
    .snap_valid  (f_valid),
    .snap_ready  (f_ready),
    .snap_tp     (f_tp),
    .snap_fp     (f_fp),
    .snap_fn     (f_fn),
    .snap_tn     (f_tn),
    .snap_ex     (f_ex),
    .snap_sat    (f_sat)
  );

  assign f_data = {f_sat, f_ex, f_tn, f_fn, f_fp, f_tp};

  smm_queue #(
    .WIDTH (SNAP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  smm_back #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .snap_valid        (b_valid),
    .snap_ready        (b_ready),
    .snap_tp           (b_data[COUNT_BITS-1:0]),
    .snap_fp           (b_data[2*COUNT_BITS-1:COUNT_BITS]),
    .snap_fn           (b_data[3*COUNT_BITS-1:2*COUNT_BITS]),
    .snap_tn           (b_data[4*COUNT_BITS-1:3*COUNT_BITS]),
    .snap_ex           (b_data[5*COUNT_BITS-1:4*COUNT_BITS]),
    .snap_sat          (b_data[SNAP_W-1]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .dice_ratio        (dice_ratio),
    .jaccard_ratio     (jaccard_ratio),
    .specificity_ratio (specificity_ratio),
    .recall_ratio      (recall_ratio),
    .count_saturated   (count_saturated)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dice_ratio <= ONE_Q) && (jaccard_ratio <= ONE_Q)
              && (specificity_ratio <= ONE_Q) && (recall_ratio <= ONE_Q))
    else $error("ratio above one");

  a_jaccard_le_dice: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (jaccard_ratio <= dice_ratio))
    else $error("jaccard above dice");

  a_last_needs_room: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_pixel) |-> f_ready)
    else $error("frame counts pushed into a full queue");
`endif

endmodule
`default_nettype wire
